FILE: rtl/tbna_pkg.sv
// tbna_pkg: shared types and constants for the two-bit-weight neuron accumulator
// item structs for the request and result channels, reset values of the tracked state
// no dependencies
`default_nettype none

package tbna_pkg;

   localparam int ActWidth = 8;
   localparam int AccWidth = 16;
   localparam int SumWidth = 10;
   localparam int NumLanes = 4;
   localparam int ValueLsb = 3;

   localparam logic [7:0] BestScoreReset = 8'h81;
   localparam logic [7:0] BestIndexReset = 8'd127;

   typedef struct packed {
      logic [7:0]        weight_byte;
      logic signed [7:0] act_a;
      logic signed [7:0] act_b;
      logic signed [7:0] act_c;
      logic signed [7:0] act_d;
      logic              neuron_done;
      logic              layer_done;
   } req_type;

   typedef struct packed {
      logic [6:0] neuron_value;
      logic [7:0] neuron_number;
      logic       layer_end;
      logic [7:0] best_class;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/tbna_terms.sv
// tbna_terms: forms the four weighted activations of one item and their sum
// each weight pair's low bit doubles and high bit negates its activation, with 8-bit wrap
// depends on tbna_pkg
`default_nettype none

module tbna_terms (
   input  var tbna_pkg::req_type                     item,
   output logic signed [tbna_pkg::SumWidth-1:0]      term_sum
);
   import tbna_pkg::*;

   logic [ActWidth-1:0]        act_lane [NumLanes];
   logic [1:0]                 wbits    [NumLanes];
   logic [ActWidth-1:0]        dbl      [NumLanes];
   logic [ActWidth-1:0]        neg      [NumLanes];
   logic signed [SumWidth-1:0] ext      [NumLanes];

   assign act_lane[0] = item.act_a;
   assign act_lane[1] = item.act_b;
   assign act_lane[2] = item.act_c;
   assign act_lane[3] = item.act_d;

   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         wbits[i] = item.weight_byte[2*(NumLanes-1-i) +: 2];
         dbl[i]   = wbits[i][0] ? {act_lane[i][ActWidth-2:0], 1'b0} : act_lane[i];
         neg[i]   = wbits[i][1] ? ActWidth'(-dbl[i]) : dbl[i];
         ext[i]   = SumWidth'($signed(neg[i]));
      end
   end

   assign term_sum = (ext[0] + ext[1]) + (ext[2] + ext[3]);

endmodule

`default_nettype wire

FILE: rtl/tbna_core.sv
// tbna_core: neuron accumulator, neuron counter and per-layer argmax tracker
// builds the result item for the item that closes a neuron
// depends on tbna_pkg
`default_nettype none

module tbna_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  var tbna_pkg::req_type                item,
   input  logic signed [tbna_pkg::SumWidth-1:0] term_sum,
   output tbna_pkg::rsp_type                    result
);
   import tbna_pkg::*;

   logic [AccWidth-1:0] acc_ff, acc_in;
   logic [7:0]          counter_ff, counter_in;
   logic [7:0]          best_score_ff, best_score_in;
   logic [7:0]          best_index_ff, best_index_in;
   logic [AccWidth-1:0] acc_next;
   logic [7:0]          mid;
   logic [7:0]          low;
   logic                better;
   logic [7:0]          idx_now;

   assign acc_next = acc_ff + AccWidth'(term_sum);
   assign mid      = acc_next[ValueLsb +: 8];
   assign low      = acc_next[7:0];
   assign better   = $signed(low) > $signed(best_score_ff);
   assign idx_now  = better ? counter_ff : best_index_ff;

   assign result.neuron_value  = mid[7] ? 7'd0 : mid[6:0];
   assign result.neuron_number = counter_ff;
   assign result.layer_end     = item.layer_done;
   assign result.best_class    = idx_now;

   always_comb begin
      acc_in        = acc_ff;
      counter_in    = counter_ff;
      best_score_in = best_score_ff;
      best_index_in = best_index_ff;
      if (step) begin
         if (!item.neuron_done) begin
            acc_in = acc_next;
         end else if (item.layer_done) begin
            acc_in        = '0;
            counter_in    = '0;
            best_score_in = BestScoreReset;
            best_index_in = BestIndexReset;
         end else begin
            acc_in        = '0;
            counter_in    = counter_ff + 8'd1;
            best_score_in = better ? low : best_score_ff;
            best_index_in = idx_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         counter_ff    <= '0;
         best_score_ff <= BestScoreReset;
         best_index_ff <= BestIndexReset;
      end else begin
         acc_ff        <= acc_in;
         counter_ff    <= counter_in;
         best_score_ff <= best_score_in;
         best_index_ff <= best_index_in;
      end
   end

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      step && item.neuron_done |=> acc_ff == '0)
      else $error("accumulator not cleared after neuron end");

   a_layer_restart: assert property (@(posedge clock) disable iff (reset)
      step && item.neuron_done && item.layer_done |=>
         counter_ff == '0 && best_index_ff == BestIndexReset &&
         best_score_ff == BestScoreReset)
      else $error("layer state not restarted");

   a_best_consistent: assert property (@(posedge clock) disable iff (reset)
      best_index_ff != BestIndexReset |-> $signed(best_score_ff) > $signed(BestScoreReset))
      else $error("best index set without a winning score");

endmodule

`default_nettype wire

FILE: rtl/two_bit_weight_neuron_accumulator.sv
// two_bit_weight_neuron_accumulator: top level, input register, result register
// instantiates tbna_terms and tbna_core, depends on tbna_pkg
//
// usage
//   req channel: one item per weight byte with four signed activations; neuron_done
//   marks the last byte of a neuron, layer_done with it marks the last neuron
//   rsp channel: one item per finished neuron with its clamped value, its number,
//   the layer end flag and the best neuron index so far in the layer
//   path: an item is registered in the input register at acceptance, and its
//   result is registered in the result register, which drives rsp
//   throughput: one item per cycle unless an item that closes a neuron stalls, with
//   the four terms added combinationally into the accumulator
//   stall: while a result waits on rsp_ready, items that close no neuron keep
//   flowing; the next item that closes a neuron holds in the input register
//   and blocks req until the result register frees
//   reset: accumulator and neuron count clear, best score goes to -127 and best
//   index to 127, both registers empty
`default_nettype none

module two_bit_weight_neuron_accumulator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  var tbna_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbna_pkg::rsp_type rsp_item
);
   import tbna_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   req_type                    s1_item_ff, s1_item_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_item_ff, rsp_item_in;
   logic                       out_free;
   logic                       s1_fire;
   logic                       emit;
   logic signed [SumWidth-1:0] term_sum;
   rsp_type                    result;

   tbna_terms u_terms (
      .item     (s1_item_ff),
      .term_sum (term_sum)
   );

   tbna_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (s1_fire),
      .item     (s1_item_ff),
      .term_sum (term_sum),
      .result   (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_item_ff.neuron_done || out_free);
   assign emit      = s1_fire && s1_item_ff.neuron_done;
   assign req_ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_item_in  = req_item;
      end
      rsp_item_in = rsp_item_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("held input item lost or changed");

   a_emit_shown: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("result not shown after neuron end");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

FILE: bench/neuron_result_checker.sv
// neuron_result_checker: watches both channels of the two-bit-weight neuron accumulator,
// predicts each finished neuron and compares the results field by field in arrival order
// depends on tbna_pkg
module neuron_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tbna_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tbna_pkg::rsp_type rsp_item,
   output int                mismatch_count,
   output int                neurons_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;
   import tbna_pkg::*;

   logic [15:0] neuron_sum;
   logic [15:0] running_sum;
   logic [7:0]  neuron_index;
   logic [7:0]  top_score;
   logic [7:0]  top_index;
   logic [7:0]  mid_byte;
   rsp_type     predicted;
   rsp_type     oldest;
   rsp_type     pending_neurons[$];
   int          errors = 0;

   // double with 8-bit wrap if code bit 0 is set, then negate with 8-bit wrap if code bit 1 is set, then sign-extend
   function automatic logic [15:0] lane_term(input logic [1:0] code, input logic [7:0] act);
      logic [7:0] v;
      v = act;
      if (code[0]) begin
         v = {v[6:0], 1'b0};
      end
      if (code[1]) begin
         v = 8'd0 - v;
      end
      return {{8{v[7]}}, v};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         neuron_sum = '0;
         neuron_index = '0;
         top_score = BestScoreReset;
         top_index = BestIndexReset;
         pending_neurons.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_neurons.size() == 0) begin
               errors++;
               $error("neuron result for neuron %0d with no prediction waiting",
                      rsp_item.neuron_number);
            end else begin
               oldest = pending_neurons.pop_front();
               if (rsp_item.neuron_value !== oldest.neuron_value) begin
                  errors++;
                  $error("neuron_value: expected %0d, got %0d",
                         oldest.neuron_value, rsp_item.neuron_value);
               end
               if (rsp_item.neuron_number !== oldest.neuron_number) begin
                  errors++;
                  $error("neuron_number: expected %0d, got %0d",
                         oldest.neuron_number, rsp_item.neuron_number);
               end
               if (rsp_item.layer_end !== oldest.layer_end) begin
                  errors++;
                  $error("layer_end: expected %0d, got %0d",
                         oldest.layer_end, rsp_item.layer_end);
               end
               if (rsp_item.best_class !== oldest.best_class) begin
                  errors++;
                  $error("best_class: expected %0d, got %0d",
                         oldest.best_class, rsp_item.best_class);
               end
            end
         end
         if (req_valid && req_ready) begin
            running_sum = neuron_sum
                        + lane_term(req_item.weight_byte[7:6], req_item.act_a)
                        + lane_term(req_item.weight_byte[5:4], req_item.act_b)
                        + lane_term(req_item.weight_byte[3:2], req_item.act_c)
                        + lane_term(req_item.weight_byte[1:0], req_item.act_d);
            if (req_item.neuron_done) begin
               mid_byte = running_sum[ValueLsb +: 8];
               // strict compare on the low byte, ties keep the earlier neuron
               if ($signed(running_sum[7:0]) > $signed(top_score)) begin
                  top_score = running_sum[7:0];
                  top_index = neuron_index;
               end
               predicted.neuron_value = mid_byte[7] ? 7'd0 : mid_byte[6:0];
               predicted.neuron_number = neuron_index;
               predicted.layer_end = req_item.layer_done;
               predicted.best_class = top_index;
               pending_neurons.push_back(predicted);
               neuron_sum = '0;
               if (req_item.layer_done) begin
                  neuron_index = '0;
                  top_score = BestScoreReset;
                  top_index = BestIndexReset;
               end else begin
                  neuron_index = neuron_index + 8'd1;
               end
            end else begin
               neuron_sum = running_sum;
            end
         end
      end
      mismatch_count <= errors;
      neurons_in_flight <= pending_neurons.size();
   end

endmodule

FILE: bench/two_bit_weight_neuron_accumulator_test.sv
// two_bit_weight_neuron_accumulator_test: clock, reset, item stimulus and verdict
// drives the accumulator with directed and random neurons and layers, bursty sender,
// stalling receiver; depends on tbna_pkg, neuron_result_checker and the block itself
module two_bit_weight_neuron_accumulator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tbna_pkg::*;

   localparam int IdleLimit = 3000;
   localparam int HoldCycles = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   int mismatch_count;
   int neurons_in_flight;
   int items_sent = 0;
   int neurons_sent = 0;
   int layers_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;

   two_bit_weight_neuron_accumulator DUT (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_item,
      .rsp_valid,
      .rsp_ready,
      .rsp_item
   );

   neuron_result_checker neuron_check (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_item,
      .rsp_valid,
      .rsp_ready,
      .rsp_item,
      .mismatch_count,
      .neurons_in_flight
   );

   always #5 clock = ~clock;

   function automatic req_type item_of(input logic [7:0] w, input logic [7:0] a,
                                       input logic [7:0] b, input logic [7:0] c,
                                       input logic [7:0] d, input logic nd, input logic ld);
      req_type it;
      it.weight_byte = w;
      it.act_a = a;
      it.act_b = b;
      it.act_c = c;
      it.act_d = d;
      it.neuron_done = nd;
      it.layer_done = ld;
      return it;
   endfunction

   function automatic logic [7:0] pick_act();
      case ($urandom_range(0, 9))
         0: begin
            return 8'h80;
         end
         1: begin
            return 8'h7F;
         end
         2: begin
            return 8'h00;
         end
         3: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   task automatic push_item(input req_type it);
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      items_sent++;
      if (it.neuron_done) begin
         neurons_sent++;
         if (it.layer_done) begin
            layers_sent++;
         end
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   task automatic settle_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (neurons_in_flight != 0) begin
         @(posedge clock);
      end
   endtask

   // neurons of random length; a stray layer mark on a non-final item is ignored
   task automatic random_layer(input int max_neurons, input int max_len);
      int   n;
      int   len;
      logic last;
      n = $urandom_range(1, max_neurons);
      for (int k = 0; k < n; k++) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, max_len) : $urandom_range(1, 4);
         for (int j = 0; j < len; j++) begin
            last = (j == len - 1);
            push_item(item_of(8'($urandom), pick_act(), pick_act(), pick_act(), pick_act(),
                              last, last ? (k == n - 1) : ($urandom_range(0, 7) == 0)));
         end
      end
   endtask

   initial begin
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("no item moved for %0d cycles", IdleLimit);
      $display("two_bit_weight_neuron_accumulator regression: fail");
      $finish;
   end

   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
         @(posedge clock);
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lane extremes, doubling and negation wrap, clamp, argmax ties
      push_item(item_of(8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0, 1'b0));
      push_item(item_of(8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b0));
      push_item(item_of(8'h55, 8'h80, 8'h7F, 8'hFF, 8'h01, 1'b1, 1'b0));
      push_item(item_of(8'hAA, 8'h80, 8'h7F, 8'hFF, 8'h01, 1'b1, 1'b0));
      push_item(item_of(8'hFF, 8'h80, 8'h7F, 8'hFF, 8'h40, 1'b1, 1'b0));
      push_item(item_of(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
      push_item(item_of(8'h00, 8'h05, 8'h05, 8'h05, 8'h05, 1'b0, 1'b1));
      push_item(item_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
      // scores of -127 and -128 never beat the reset score
      push_item(item_of(8'h00, 8'h81, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
      push_item(item_of(8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
      push_item(item_of(8'h1B, 8'h80, 8'h7F, 8'h80, 8'h7F, 1'b1, 1'b0));
      push_item(item_of(8'hE4, 8'h7F, 8'h80, 8'h7F, 8'h80, 1'b1, 1'b0));
      push_item(item_of(8'hF0, 8'h7F, 8'h7F, 8'h00, 8'h00, 1'b1, 1'b1));

      // long neurons that wrap the 16-bit sum both ways
      for (int j = 0; j < 70; j++) begin
         push_item(item_of(8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h7F, j == 69, 1'b0));
      end
      for (int j = 0; j < 70; j++) begin
         push_item(item_of(8'hAA, 8'h80, 8'h80, 8'h80, 8'h80, j == 69, j == 69));
      end

      while (items_sent < 450) begin
         random_layer(10, 20);
      end

      // receiver holds off while one-item neurons keep coming, then drain fully
      hold_rsp = 1'b1;
      for (int k = 0; k < 24; k++) begin
         push_item(item_of(8'($urandom), pick_act(), pick_act(), pick_act(), pick_act(),
                           1'b1, k == 23));
      end
      settle_outputs();

      // one layer long enough for the neuron number to wrap
      for (int k = 0; k < 260; k++) begin
         push_item(item_of(8'($urandom), pick_act(), pick_act(), pick_act(), pick_act(),
                           1'b1, k == 259));
      end

      while (items_sent < 1050) begin
         random_layer(10, 20);
      end

      settle_outputs();
      repeat (8) @(posedge clock);

      $display("covered %0d items, %0d neuron results and %0d layer closes", items_sent,
               neurons_sent, layers_sent);
      $display("including wrapping sums, a long receiver hold-off and a neuron count past 255");
      if (mismatch_count == 0 && neurons_in_flight == 0) begin
         $display("two_bit_weight_neuron_accumulator regression: pass");
      end else begin
         $display("two_bit_weight_neuron_accumulator regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/tbna_pkg.sv
rtl/tbna_terms.sv
rtl/tbna_core.sv
rtl/two_bit_weight_neuron_accumulator.sv
bench/neuron_result_checker.sv
bench/two_bit_weight_neuron_accumulator_test.sv
